/* src/dll_pkg.sv */
package dll_pkg;

  // List operations
  typedef enum logic [3:0] {
    MODE_CLEAR      = 4'd0,
    MODE_INS_FIRST  = 4'd1,
    MODE_INS_LAST   = 4'd2,
    MODE_CUR_FIRST  = 4'd3,
    MODE_CUR_LAST   = 4'd4,
    MODE_DEL_FIRST  = 4'd5,
    MODE_DEL_LAST   = 4'd6,
    MODE_DEL_AFTER  = 4'd7,
    MODE_DEL_BEFORE = 4'd8,
    MODE_INS_AFTER  = 4'd9,
    MODE_INS_BEFORE = 4'd10,
    MODE_WRITE      = 4'd11,
    MODE_NEXT       = 4'd12,
    MODE_PREV       = 4'd13
  } mode_e;

  // Result status
  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  // Sequencer states
  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_DPTR  = 10'b00_0000_0010,
    S_DLINK = 10'b00_0000_0100,
    S_DDATA = 10'b00_0000_1000,
    S_MOVE  = 10'b00_0001_0000,
    S_CDATA = 10'b00_0010_0000,
    S_ALLOC = 10'b00_0100_0000,
    S_LINK1 = 10'b00_1000_0000,
    S_LINK2 = 10'b01_0000_0000,
    S_FIN   = 10'b10_0000_0000
  } state_e;

endpackage

/* src/dll_ram.sv */
module dll_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry, register the read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/doubly_linked_list_engine.sv */
// Channel | valid      | stall       | payload
// request | in_valid_i | in_stall_o  | mode_i, value_i
// result  | out_valid_o| out_stall_i | status_o .. node_count_o
//
// One request at a time. Clear, cursor first/last, write and requests ignored
// at once go straight to the final step; next/prev, deletes and inserts pass
// through further steps, as the node memories register their reads.
// Reset empties the list at once; node memories are never cleared.
// A waiting result holds the sequencer in its final step; a new request is
// taken while the previous result still waits.
module doubly_linked_list_engine #(
  parameter int NODES = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [3:0]                  mode_i,
  input  logic signed [31:0]          value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic                        cursor_active_o,
  output logic                        list_empty_o,
  output logic signed [31:0]          head_value_o,
  output logic signed [31:0]          tail_value_o,
  output logic signed [31:0]          cursor_value_o,
  output logic [$clog2(NODES):0]      node_count_o
);
  import dll_pkg::*;

  localparam int AW = $clog2(NODES);
  localparam int PW = AW + 1;
  localparam logic [PW-1:0] NIL = PW'(NODES);

  state_e          state_q, state_d;
  mode_e           op_q, op_d;
  status_e         st_q, st_d;
  logic [31:0]     val_q, val_d;
  logic [PW-1:0]   head_q, head_d, tail_q, tail_d, cur_q, cur_d;
  logic [PW-1:0]   p_q, p_d, a_q, a_d, b_q, b_d, n_q, n_d;
  logic [PW-1:0]   count_q, count_d, top_q, top_d, fresh_q, fresh_d;
  logic [31:0]     hd_q, hd_d, td_q, td_d, cd_q, cd_d;
  logic            hsel_q, hsel_d, stack_q, stack_d;

  logic            ov_q, ov_d;
  status_e         ost_q, ost_d;
  logic            oca_q, oca_d, oem_q, oem_d;
  logic [31:0]     ohd_q, ohd_d, otd_q, otd_d, ocd_q, ocd_d;
  logic [PW-1:0]   ocnt_q, ocnt_d;

  logic            d_we, pv_we, nx_we, f_we;
  logic [AW-1:0]   d_wa, d_ra, pv_wa, pv_ra, nx_wa, nx_ra, f_wa, f_ra;
  logic [31:0]     d_wd, d_rd;
  logic [PW-1:0]   pv_wd, pv_rd, nx_wd, nx_rd;
  logic [AW-1:0]   f_wd, f_rd;

  function automatic logic nd(input logic [PW-1:0] x);
    return x < NIL;
  endfunction

  function automatic logic [PW-1:0] lnk(input logic [PW-1:0] x);
    return (x < NIL) ? x : NIL;
  endfunction

  // Node pool and free stack
  dll_ram #(.WIDTH(32), .DEPTH(NODES)) u_data (
    .clk_i(clk_i), .we_i(d_we), .waddr_i(d_wa), .wdata_i(d_wd),
    .raddr_i(d_ra), .rdata_o(d_rd));
  dll_ram #(.WIDTH(PW), .DEPTH(NODES)) u_prev (
    .clk_i(clk_i), .we_i(pv_we), .waddr_i(pv_wa), .wdata_i(pv_wd),
    .raddr_i(pv_ra), .rdata_o(pv_rd));
  dll_ram #(.WIDTH(PW), .DEPTH(NODES)) u_next (
    .clk_i(clk_i), .we_i(nx_we), .waddr_i(nx_wa), .wdata_i(nx_wd),
    .raddr_i(nx_ra), .rdata_o(nx_rd));
  dll_ram #(.WIDTH(AW), .DEPTH(NODES)) u_free (
    .clk_i(clk_i), .we_i(f_we), .waddr_i(f_wa), .wdata_i(f_wd),
    .raddr_i(f_ra), .rdata_o(f_rd));

  assign in_stall_o = (state_q != S_IDLE);

  // Sequence one request
  always_comb begin
    logic [PW-1:0] x;
    logic [PW-1:0] la;
    logic [PW-1:0] lb;
    logic          can_take;
    state_d = state_q; op_d = op_q; st_d = st_q; val_d = val_q;
    head_d = head_q; tail_d = tail_q; cur_d = cur_q;
    p_d = p_q; a_d = a_q; b_d = b_q; n_d = n_q;
    count_d = count_q; top_d = top_q; fresh_d = fresh_q;
    hd_d = hd_q; td_d = td_q; cd_d = cd_q; hsel_d = hsel_q; stack_d = stack_q;
    ov_d = ov_q & out_stall_i; ost_d = ost_q; oca_d = oca_q; oem_d = oem_q;
    ohd_d = ohd_q; otd_d = otd_q; ocd_d = ocd_q; ocnt_d = ocnt_q;
    d_we = 1'b0; d_wa = '0; d_wd = '0; d_ra = '0;
    pv_we = 1'b0; pv_wa = '0; pv_wd = '0; pv_ra = '0;
    nx_we = 1'b0; nx_wa = '0; nx_wd = '0; nx_ra = '0;
    f_we = 1'b0; f_wa = '0; f_wd = '0; f_ra = '0;
    x = NIL;
    la = lnk(pv_rd);
    lb = lnk(nx_rd);
    can_take = (top_q != '0) || (fresh_q < NIL);

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d = mode_e'(mode_i);
          val_d = value_i;
          st_d = ST_DONE;
          state_d = S_FIN;
          unique case (mode_e'(mode_i))
            MODE_CLEAR: begin
              top_d = '0; fresh_d = '0; count_d = '0;
              head_d = NIL; tail_d = NIL; cur_d = NIL;
              hd_d = '0; td_d = '0; cd_d = '0;
            end
            MODE_INS_FIRST, MODE_INS_LAST, MODE_INS_AFTER, MODE_INS_BEFORE: begin
              if ((mode_i == MODE_INS_AFTER || mode_i == MODE_INS_BEFORE) && !nd(cur_q)) begin
                st_d = ST_IGNORED;
              end else if (!can_take) begin
                st_d = ST_FULL;
              end else begin
                a_d = (mode_i == MODE_INS_FIRST) ? NIL :
                      (mode_i == MODE_INS_LAST) ? tail_q : cur_q;
                b_d = (mode_i == MODE_INS_FIRST) ? head_q :
                      (mode_i == MODE_INS_LAST) ? NIL : cur_q;
                pv_ra = cur_q[AW-1:0];
                nx_ra = cur_q[AW-1:0];
                // Pop a freed node, else hand out a fresh one
                if (top_q != '0) begin
                  f_ra = AW'(top_q - PW'(1));
                  top_d = top_q - PW'(1);
                  stack_d = 1'b1;
                end else begin
                  n_d = fresh_q;
                  fresh_d = fresh_q + PW'(1);
                  stack_d = 1'b0;
                end
                state_d = S_ALLOC;
              end
            end
            MODE_CUR_FIRST: begin
              cur_d = head_q; cd_d = hd_q;
            end
            MODE_CUR_LAST: begin
              cur_d = tail_q; cd_d = td_q;
            end
            MODE_DEL_FIRST, MODE_DEL_LAST: begin
              x = (mode_i == MODE_DEL_FIRST) ? head_q : tail_q;
              if (!nd(x)) begin
                st_d = ST_IGNORED;
              end else begin
                p_d = x;
                pv_ra = x[AW-1:0];
                nx_ra = x[AW-1:0];
                state_d = S_DLINK;
              end
            end
            MODE_DEL_AFTER: begin
              if (!nd(cur_q) || cur_q == tail_q) begin
                st_d = ST_IGNORED;
              end else begin
                nx_ra = cur_q[AW-1:0];
                state_d = S_DPTR;
              end
            end
            MODE_DEL_BEFORE: begin
              if (!nd(cur_q) || cur_q == head_q) begin
                st_d = ST_IGNORED;
              end else begin
                pv_ra = cur_q[AW-1:0];
                state_d = S_DPTR;
              end
            end
            MODE_WRITE: begin
              if (!nd(cur_q)) begin
                st_d = ST_IGNORED;
              end else begin
                d_we = 1'b1; d_wa = cur_q[AW-1:0]; d_wd = value_i;
                cd_d = value_i;
                if (cur_q == head_q) hd_d = value_i;
                if (cur_q == tail_q) td_d = value_i;
              end
            end
            MODE_NEXT, MODE_PREV: begin
              if (!nd(cur_q)) begin
                st_d = ST_IGNORED;
              end else begin
                pv_ra = cur_q[AW-1:0];
                nx_ra = cur_q[AW-1:0];
                state_d = S_MOVE;
              end
            end
            default: st_d = ST_IGNORED;
          endcase
        end
      end
      S_DPTR: begin
        x = (op_q == MODE_DEL_AFTER) ? lb : la;
        if (!nd(x)) begin
          st_d = ST_IGNORED;
          state_d = S_FIN;
        end else begin
          p_d = x;
          pv_ra = x[AW-1:0];
          nx_ra = x[AW-1:0];
          state_d = S_DLINK;
        end
      end
      S_DLINK: begin
        // Bridge the neighbours over the node
        if (nd(la)) begin
          nx_we = 1'b1; nx_wa = la[AW-1:0]; nx_wd = lb;
        end else begin
          head_d = lb;
        end
        if (nd(lb)) begin
          pv_we = 1'b1; pv_wa = lb[AW-1:0]; pv_wd = la;
        end else begin
          tail_d = la;
        end
        if (cur_q == p_q) begin
          cur_d = NIL; cd_d = '0;
        end
        // Push the node onto the free stack
        if (top_q < NIL) begin
          f_we = 1'b1; f_wa = top_q[AW-1:0]; f_wd = p_q[AW-1:0];
          top_d = top_q + PW'(1);
        end
        if (count_q != '0) count_d = count_q - PW'(1);
        state_d = S_FIN;
        if (!nd(la) && nd(lb)) begin
          d_ra = lb[AW-1:0]; hsel_d = 1'b1; state_d = S_DDATA;
        end else if (nd(la) && !nd(lb)) begin
          d_ra = la[AW-1:0]; hsel_d = 1'b0; state_d = S_DDATA;
        end else if (!nd(la) && !nd(lb)) begin
          hd_d = '0; td_d = '0;
        end
      end
      S_DDATA: begin
        if (hsel_q) hd_d = d_rd;
        else td_d = d_rd;
        state_d = S_FIN;
      end
      S_MOVE: begin
        x = (op_q == MODE_NEXT) ? lb : la;
        cur_d = x;
        if (nd(x)) begin
          d_ra = x[AW-1:0];
          state_d = S_CDATA;
        end else begin
          cd_d = '0;
          state_d = S_FIN;
        end
      end
      S_CDATA: begin
        cd_d = d_rd;
        state_d = S_FIN;
      end
      S_ALLOC: begin
        if (stack_q) n_d = {1'b0, f_rd};
        if (op_q == MODE_INS_AFTER) b_d = lb;
        if (op_q == MODE_INS_BEFORE) a_d = la;
        state_d = S_LINK1;
      end
      S_LINK1: begin
        // Fill the new node
        d_we = 1'b1; d_wa = n_q[AW-1:0]; d_wd = val_q;
        pv_we = 1'b1; pv_wa = n_q[AW-1:0]; pv_wd = a_q;
        nx_we = 1'b1; nx_wa = n_q[AW-1:0]; nx_wd = b_q;
        state_d = S_LINK2;
      end
      S_LINK2: begin
        // Point the neighbours at the new node
        if (nd(a_q)) begin
          nx_we = 1'b1; nx_wa = a_q[AW-1:0]; nx_wd = n_q;
        end else begin
          head_d = n_q; hd_d = val_q;
        end
        if (nd(b_q)) begin
          pv_we = 1'b1; pv_wa = b_q[AW-1:0]; pv_wd = n_q;
        end else begin
          tail_d = n_q; td_d = val_q;
        end
        count_d = count_q + PW'(1);
        state_d = S_FIN;
      end
      S_FIN: begin
        // Hand over the result once the output register is free
        if (!ov_q || !out_stall_i) begin
          ov_d = 1'b1;
          ost_d = st_q;
          oca_d = nd(cur_q);
          oem_d = !nd(head_q);
          ohd_d = nd(head_q) ? hd_q : '0;
          otd_d = nd(tail_q) ? td_q : '0;
          ocd_d = nd(cur_q) ? cd_q : '0;
          ocnt_d = nd(head_q) ? count_q : '0;
          count_d = nd(head_q) ? count_q : '0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control and list registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q <= NIL; tail_q <= NIL; cur_q <= NIL;
      count_q <= '0; top_q <= '0; fresh_q <= '0;
      hd_q <= '0; td_q <= '0; cd_q <= '0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q <= head_d; tail_q <= tail_d; cur_q <= cur_d;
      count_q <= count_d; top_q <= top_d; fresh_q <= fresh_d;
      hd_q <= hd_d; td_q <= td_d; cd_q <= cd_d;
      ov_q <= ov_d;
    end
  end

  // Working and result payload
  always_ff @(posedge clk_i) begin
    op_q <= op_d; st_q <= st_d; val_q <= val_d;
    p_q <= p_d; a_q <= a_d; b_q <= b_d; n_q <= n_d;
    hsel_q <= hsel_d; stack_q <= stack_d;
    ost_q <= ost_d; oca_q <= oca_d; oem_q <= oem_d;
    ohd_q <= ohd_d; otd_q <= otd_d; ocd_q <= ocd_d; ocnt_q <= ocnt_d;
  end

  assign out_valid_o     = ov_q;
  assign status_o        = ost_q;
  assign cursor_active_o = oca_q;
  assign list_empty_o    = oem_q;
  assign head_value_o    = ohd_q;
  assign tail_value_o    = otd_q;
  assign cursor_value_o  = ocd_q;
  assign node_count_o    = ocnt_q;

endmodule

/* tb/sv/list_checker.sv */
`timescale 1ns / 100ps

module list_checker #(
  parameter int NODES = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  logic [3:0]             mode_i,
  input  logic signed [31:0]     value_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  logic [1:0]             status_i,
  input  logic                   cursor_active_i,
  input  logic                   list_empty_i,
  input  logic signed [31:0]     head_value_i,
  input  logic signed [31:0]     tail_value_i,
  input  logic signed [31:0]     cursor_value_i,
  input  logic [$clog2(NODES):0] node_count_i,
  output int                     fail_count_o,
  output int                     pending_o
);
  import dll_pkg::*;

  localparam int PW  = $clog2(NODES) + 1;
  localparam int NIL = NODES;

  typedef struct packed {
    logic [1:0]     status;
    logic           cursor_active;
    logic           list_empty;
    logic [31:0]    head_value;
    logic [31:0]    tail_value;
    logic [31:0]    cursor_value;
    logic [PW-1:0]  node_count;
  } list_view_t;

  // Shadow copy of the node pool and list pointers
  logic [31:0]   shadow_data [NODES];
  int            shadow_prev [NODES];
  int            shadow_next [NODES];
  int            spare_stack [NODES];
  int            spare_top, fresh_next, head_p, tail_p, cursor_p, length;
  list_view_t    expected_views [$];

  function automatic bit is_node(int p);
    return p >= 0 && p < NIL;
  endfunction

  function automatic int prev_of(int p);
    if (!is_node(p)) return NIL;
    return is_node(shadow_prev[p]) ? shadow_prev[p] : NIL;
  endfunction

  function automatic int next_of(int p);
    if (!is_node(p)) return NIL;
    return is_node(shadow_next[p]) ? shadow_next[p] : NIL;
  endfunction

  function automatic logic [31:0] data_at(int p);
    return is_node(p) ? shadow_data[p] : 32'd0;
  endfunction

  function automatic int alloc_node();
    if (spare_top > 0) begin
      spare_top--;
      return spare_stack[spare_top];
    end
    if (fresh_next < NODES) begin
      fresh_next++;
      return fresh_next - 1;
    end
    return NIL;
  endfunction

  function automatic void unlink(int p);
    int a, b;
    a = prev_of(p);
    b = next_of(p);
    if (is_node(a)) shadow_next[a] = b; else head_p = b;
    if (is_node(b)) shadow_prev[b] = a; else tail_p = a;
    if (cursor_p == p) cursor_p = NIL;
    if (spare_top < NODES) begin
      spare_stack[spare_top] = p;
      spare_top++;
    end
    if (length > 0) length--;
  endfunction

  function automatic void link_in(int n, int a, int b, logic [31:0] v);
    shadow_data[n] = v;
    shadow_prev[n] = a;
    shadow_next[n] = b;
    if (is_node(a)) shadow_next[a] = n; else head_p = n;
    if (is_node(b)) shadow_prev[b] = n; else tail_p = n;
    length++;
  endfunction

  // Apply one list operation and return the view it should produce
  function automatic list_view_t apply_operation(logic [3:0] mode, logic [31:0] v);
    list_view_t r;
    status_e    st;
    bit         cur;
    int         n;
    st  = ST_DONE;
    cur = is_node(cursor_p);
    case (mode)
      MODE_CLEAR: begin
        spare_top = 0; fresh_next = 0; length = 0;
        head_p = NIL; tail_p = NIL; cursor_p = NIL;
      end
      MODE_INS_FIRST, MODE_INS_LAST: begin
        n = alloc_node();
        if (!is_node(n)) st = ST_FULL;
        else if (mode == MODE_INS_FIRST) link_in(n, NIL, head_p, v);
        else link_in(n, tail_p, NIL, v);
      end
      MODE_CUR_FIRST: cursor_p = head_p;
      MODE_CUR_LAST:  cursor_p = tail_p;
      MODE_DEL_FIRST: if (!is_node(head_p)) st = ST_IGNORED; else unlink(head_p);
      MODE_DEL_LAST:  if (!is_node(tail_p)) st = ST_IGNORED; else unlink(tail_p);
      MODE_DEL_AFTER: begin
        if (!cur || cursor_p == tail_p || !is_node(next_of(cursor_p))) st = ST_IGNORED;
        else unlink(next_of(cursor_p));
      end
      MODE_DEL_BEFORE: begin
        if (!cur || cursor_p == head_p || !is_node(prev_of(cursor_p))) st = ST_IGNORED;
        else unlink(prev_of(cursor_p));
      end
      MODE_INS_AFTER, MODE_INS_BEFORE: begin
        if (!cur) st = ST_IGNORED;
        else begin
          n = alloc_node();
          if (!is_node(n)) st = ST_FULL;
          else if (mode == MODE_INS_AFTER) link_in(n, cursor_p, next_of(cursor_p), v);
          else link_in(n, prev_of(cursor_p), cursor_p, v);
        end
      end
      MODE_WRITE: if (!cur) st = ST_IGNORED; else shadow_data[cursor_p] = v;
      MODE_NEXT:  if (!cur) st = ST_IGNORED; else cursor_p = next_of(cursor_p);
      MODE_PREV:  if (!cur) st = ST_IGNORED; else cursor_p = prev_of(cursor_p);
      default: st = ST_IGNORED;
    endcase
    if (!is_node(head_p)) length = 0;
    r.status        = st;
    r.cursor_active = is_node(cursor_p);
    r.list_empty    = !is_node(head_p);
    r.head_value    = data_at(head_p);
    r.tail_value    = data_at(tail_p);
    r.cursor_value  = data_at(cursor_p);
    r.node_count    = PW'(length);
    return r;
  endfunction

  assign pending_o = expected_views.size();

  // Predict on each accepted request, compare each accepted result
  always @(posedge clk_i or negedge rst_ni) begin
    list_view_t got, want;
    if (!rst_ni) begin
      spare_top = 0; fresh_next = 0; length = 0;
      head_p = NIL; tail_p = NIL; cursor_p = NIL;
      fail_count_o <= 0;
      expected_views.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '{status_i, cursor_active_i, list_empty_i, head_value_i, tail_value_i,
                cursor_value_i, node_count_i};
        if (expected_views.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_views.pop_front();
          if (got.status != want.status)
            $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
          if (got.cursor_active != want.cursor_active)
            $display("%0t: cursor_active exp %0d got %0d", $time, want.cursor_active,
                     got.cursor_active);
          if (got.list_empty != want.list_empty)
            $display("%0t: list_empty exp %0d got %0d", $time, want.list_empty,
                     got.list_empty);
          if (got.head_value != want.head_value)
            $display("%0t: head_value exp %h got %h", $time, want.head_value,
                     got.head_value);
          if (got.tail_value != want.tail_value)
            $display("%0t: tail_value exp %h got %h", $time, want.tail_value,
                     got.tail_value);
          if (got.cursor_value != want.cursor_value)
            $display("%0t: cursor_value exp %h got %h", $time, want.cursor_value,
                     got.cursor_value);
          if (got.node_count != want.node_count)
            $display("%0t: node_count exp %0d got %0d", $time, want.node_count,
                     got.node_count);
          if (got != want) fail_count_o <= fail_count_o + 1;
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_views.push_back(apply_operation(mode_i, value_i));
    end
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import dll_pkg::*;

  localparam int NODES     = 64;
  localparam int WATCHDOG  = 2000;
  localparam int RAND_REQS = 1450;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic [3:0]             mode_i = '0;
  logic signed [31:0]     value_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [1:0]             status_o;
  logic                   cursor_active_o, list_empty_o;
  logic signed [31:0]     head_value_o, tail_value_o, cursor_value_o;
  logic [$clog2(NODES):0] node_count_o;
  int                     fail_count, pending, idle_cycles;
  bit                     timed_out;
  int                     burst_left;
  bit                     back_pressure;

  doubly_linked_list_engine #(.NODES(NODES)) dut (.*);

  list_checker #(.NODES(NODES)) checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .mode_i, .value_i,
    .out_valid_i(out_valid_o), .out_stall_i, .status_i(status_o),
    .cursor_active_i(cursor_active_o), .list_empty_i(list_empty_o),
    .head_value_i(head_value_o), .tail_value_i(tail_value_o),
    .cursor_value_i(cursor_value_o), .node_count_i(node_count_o),
    .fail_count_o(fail_count), .pending_o(pending));

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver stall pattern: long clear stretches and bursts of stall
  always @(negedge clk_i) begin
    if (!back_pressure) out_stall_i <= 1'b0;
    else if ($urandom_range(0, 15) == 0) out_stall_i <= !out_stall_i;
    else if (out_stall_i && $urandom_range(0, 3) == 0) out_stall_i <= 1'b0;
    if ($urandom_range(0, 199) == 0) back_pressure = !back_pressure;
  end

  // Watchdog on handshake activity
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG && !timed_out) begin
      timed_out = 1'b1;
      $display("testbench: errors");
      $finish;
    end
  end

  // Present one request and hold it until accepted
  task automatic send_request(logic [3:0] mode, logic [31:0] v);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    value_i    <= v;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    burst_left--;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Weighted mode choice; a fill bias drives the pool towards full or empty
  function automatic logic [3:0] pick_mode(bit filling);
    int r;
    r = $urandom_range(0, 99);
    if (r < 1) return MODE_CLEAR;
    if (r < 3) return 4'($urandom_range(14, 15));
    if (filling) begin
      if (r < 45) return 4'($urandom_range(MODE_INS_FIRST, MODE_INS_LAST));
      if (r < 70) return 4'($urandom_range(MODE_INS_AFTER, MODE_INS_BEFORE));
    end else if (r < 50) return 4'($urandom_range(MODE_DEL_FIRST, MODE_DEL_BEFORE));
    return 4'($urandom_range(MODE_CUR_FIRST, MODE_PREV));
  endfunction

  initial begin
    bit filling;
    idle_cycles = 0;
    burst_left = 0;
    back_pressure = 1'b0;
    timed_out = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: operations on an empty list, then boundaries of a small list
    send_request(MODE_DEL_FIRST, 0);
    send_request(MODE_DEL_LAST, 0);
    send_request(MODE_CUR_FIRST, 0);
    send_request(MODE_CUR_LAST, 0);
    send_request(MODE_INS_AFTER, 1);
    send_request(MODE_WRITE, 1);
    send_request(MODE_NEXT, 0);
    send_request(MODE_PREV, 0);
    send_request(MODE_DEL_AFTER, 0);
    send_request(MODE_INS_FIRST, 32'h7fff_ffff);
    send_request(MODE_DEL_FIRST, 0);
    send_request(MODE_INS_LAST, 32'h8000_0000);
    send_request(MODE_CUR_FIRST, 0);
    send_request(MODE_INS_BEFORE, 32'hffff_ffff);
    send_request(MODE_INS_AFTER, 32'd5);
    send_request(MODE_CUR_LAST, 0);
    send_request(MODE_INS_AFTER, 32'd6);
    send_request(MODE_DEL_BEFORE, 0);
    send_request(MODE_WRITE, 32'h1234_5678);
    send_request(MODE_NEXT, 0);
    send_request(MODE_CUR_FIRST, 0);
    send_request(MODE_PREV, 0);
    send_request(4'd14, 0);
    send_request(4'd15, 0);
    send_request(MODE_CLEAR, 0);

    // Hold off until every result has come back
    in_valid_i <= 1'b0;
    wait (pending == 0);
    @(negedge clk_i);
    back_pressure = 1'b1;

    // Random: phases of filling to pool exhaustion and draining
    filling = 1'b1;
    for (int i = 0; i < RAND_REQS; i++) begin
      if (node_count_o == NODES[6:0]) filling = 1'b0;
      if ($urandom_range(0, 79) == 0) filling = !filling;
      send_request(pick_mode(filling), pick_value());
    end
    in_valid_i <= 1'b0;

    wait (pending == 0);
    repeat (20) @(negedge clk_i);
    if (fail_count == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule

/* filelist.f */
src/dll_pkg.sv
src/dll_ram.sv
src/doubly_linked_list_engine.sv
tb/sv/list_checker.sv
tb/sv/testbench.sv
